/* hdl/cart_pkg.sv */
`default_nettype none

package cart_pkg;

    // Sample format defaults
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Q16.16 working format and shared multiplier widths
    localparam int Q_WIDTH     = 32;
    localparam int MUL_A_WIDTH = 48;
    localparam int MUL_B_WIDTH = 18;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
    localparam int WIDE_WIDTH  = 68;
    localparam int GAIN_FRAC   = 8;
    localparam int DT_FRAC     = 16;

    // Configuration port
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    // Windup bands, Q16.16
    localparam logic signed [31:0] OUTER_LIMIT = 32'sd17694720;  // 270.0
    localparam logic signed [31:0] OUTER_EDGE  = 32'sd17661952;  // 269.5
    localparam logic signed [31:0] INNER_LIMIT = 32'sd19660800;  // 300.0
    localparam logic signed [31:0] INNER_EDGE  = 32'sd19628032;  // 299.5

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Register indexes
    typedef enum logic [2:0] {
        REG_OUTER_P = 3'd0,
        REG_OUTER_I = 3'd1,
        REG_INNER_P = 3'd2,
        REG_INNER_I = 3'd3,
        REG_INNER_D = 3'd4,
        REG_TSTEP   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] outer_p_gain;
        logic signed [15:0] outer_i_gain;
        logic signed [15:0] inner_p_gain;
        logic signed [15:0] inner_i_gain;
        logic signed [15:0] inner_d_gain;
        logic        [15:0] time_step;
    } cfg_t;

    // Datapath operations, one per sequencer step
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_E1,
        OP_MUL_OP,
        OP_P1,
        OP_MUL_OI,
        OP_MUL_TS,
        OP_OI,
        OP_E2,
        OP_MUL_IP,
        OP_P2,
        OP_MUL_ID,
        OP_D2,
        OP_MUL_II,
        OP_II,
        OP_DRIVE
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E1,
        ST_MUL_OP,
        ST_P1,
        ST_MUL_OI,
        ST_MUL_TS_O,
        ST_OI,
        ST_E2,
        ST_MUL_IP,
        ST_P2,
        ST_MUL_ID,
        ST_D2,
        ST_MUL_II,
        ST_MUL_TS_I,
        ST_II,
        ST_DRIVE
    } state_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_WIDTH-1:0] v);
        logic signed [31:0] r;
        if (v > WIDE_WIDTH'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < WIDE_WIDTH'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // An integral moves freely inside its band; outside it, only back toward zero.
    function automatic logic integ_go(input logic signed [31:0] acc,
                                      input logic signed [31:0] err,
                                      input logic signed [31:0] limit,
                                      input logic signed [31:0] bound);
        logic inside_band;
        logic pull_down;
        logic pull_up;
        inside_band = (acc < limit) && (acc > -limit);
        pull_down   = (acc > bound) && (err < 32'sd0);
        pull_up     = (acc < -bound) && (err > 32'sd0);
        return inside_band || pull_down || pull_up;
    endfunction

endpackage

`default_nettype wire

/* hdl/cart_regs.sv */
`default_nettype none

module cart_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [cart_pkg::ADDR_WIDTH-1:0]    paddr,
    input  wire logic [cart_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic      [cart_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                                    pready,
    output cart_pkg::cfg_t                          cfg
);

    cart_pkg::cfg_t   cfg_reg;
    cart_pkg::cfg_t   cfg_next;
    cart_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = cart_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                cart_pkg::REG_OUTER_P: cfg_next.outer_p_gain = pwdata[15:0];
                cart_pkg::REG_OUTER_I: cfg_next.outer_i_gain = pwdata[15:0];
                cart_pkg::REG_INNER_P: cfg_next.inner_p_gain = pwdata[15:0];
                cart_pkg::REG_INNER_I: cfg_next.inner_i_gain = pwdata[15:0];
                cart_pkg::REG_INNER_D: cfg_next.inner_d_gain = pwdata[15:0];
                cart_pkg::REG_TSTEP:   cfg_next.time_step    = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            cart_pkg::REG_OUTER_P: prdata = {16'd0, cfg_reg.outer_p_gain};
            cart_pkg::REG_OUTER_I: prdata = {16'd0, cfg_reg.outer_i_gain};
            cart_pkg::REG_INNER_P: prdata = {16'd0, cfg_reg.inner_p_gain};
            cart_pkg::REG_INNER_I: prdata = {16'd0, cfg_reg.inner_i_gain};
            cart_pkg::REG_INNER_D: prdata = {16'd0, cfg_reg.inner_d_gain};
            cart_pkg::REG_TSTEP:   prdata = {16'd0, cfg_reg.time_step};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.outer_p_gain <= 16'sd256;
            cfg_reg.outer_i_gain <= 16'sd0;
            cfg_reg.inner_p_gain <= 16'sd256;
            cfg_reg.inner_i_gain <= 16'sd0;
            cfg_reg.inner_d_gain <= 16'sd0;
            cfg_reg.time_step    <= 16'd164;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/cart_ctrl.sv */
`default_nettype none

module cart_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             out_busy,
    output cart_pkg::dp_op_t      op
);

    cart_pkg::state_t state_reg;
    cart_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cart_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = cart_pkg::OP_IDLE;
        s_ready    = 1'b0;
        unique case (state_reg)
            cart_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = cart_pkg::OP_LOAD;
                    state_next = cart_pkg::ST_E1;
                end
            end
            cart_pkg::ST_E1: begin
                op         = cart_pkg::OP_E1;
                state_next = cart_pkg::ST_MUL_OP;
            end
            cart_pkg::ST_MUL_OP: begin
                op         = cart_pkg::OP_MUL_OP;
                state_next = cart_pkg::ST_P1;
            end
            cart_pkg::ST_P1: begin
                op         = cart_pkg::OP_P1;
                state_next = cart_pkg::ST_MUL_OI;
            end
            cart_pkg::ST_MUL_OI: begin
                op         = cart_pkg::OP_MUL_OI;
                state_next = cart_pkg::ST_MUL_TS_O;
            end
            cart_pkg::ST_MUL_TS_O: begin
                op         = cart_pkg::OP_MUL_TS;
                state_next = cart_pkg::ST_OI;
            end
            cart_pkg::ST_OI: begin
                op         = cart_pkg::OP_OI;
                state_next = cart_pkg::ST_E2;
            end
            cart_pkg::ST_E2: begin
                op         = cart_pkg::OP_E2;
                state_next = cart_pkg::ST_MUL_IP;
            end
            cart_pkg::ST_MUL_IP: begin
                op         = cart_pkg::OP_MUL_IP;
                state_next = cart_pkg::ST_P2;
            end
            cart_pkg::ST_P2: begin
                op         = cart_pkg::OP_P2;
                state_next = cart_pkg::ST_MUL_ID;
            end
            cart_pkg::ST_MUL_ID: begin
                op         = cart_pkg::OP_MUL_ID;
                state_next = cart_pkg::ST_D2;
            end
            cart_pkg::ST_D2: begin
                op         = cart_pkg::OP_D2;
                state_next = cart_pkg::ST_MUL_II;
            end
            cart_pkg::ST_MUL_II: begin
                op         = cart_pkg::OP_MUL_II;
                state_next = cart_pkg::ST_MUL_TS_I;
            end
            cart_pkg::ST_MUL_TS_I: begin
                op         = cart_pkg::OP_MUL_TS;
                state_next = cart_pkg::ST_II;
            end
            cart_pkg::ST_II: begin
                op         = cart_pkg::OP_II;
                state_next = cart_pkg::ST_DRIVE;
            end
            cart_pkg::ST_DRIVE: begin
                // Hold here until the output register can take the new word.
                if (!out_busy) begin
                    op         = cart_pkg::OP_DRIVE;
                    state_next = cart_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cart_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/cart_dp.sv */
`default_nettype none

module cart_dp #(
    parameter int SAMPLE_WIDTH  = cart_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = cart_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire cart_pkg::dp_op_t               op,
    input  wire cart_pkg::cfg_t                 cfg,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_target_angle,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_measured_angle,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_measured_rate,
    output logic                                out_busy,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [31:0]                  m_drive
);

    localparam int SHIFT = 16 - FRACTION_BITS;
    localparam int MW    = cart_pkg::MUL_A_WIDTH;
    localparam int BW    = cart_pkg::MUL_B_WIDTH;
    localparam int PW    = cart_pkg::PROD_WIDTH;
    localparam int WW    = cart_pkg::WIDE_WIDTH;

    logic signed [31:0] tgt_reg, ang_reg, rate_reg;
    logic signed [31:0] err_reg, err_next;          // e1, then e2
    logic signed [31:0] p1_reg, p1_next;
    logic signed [31:0] p2_reg, p2_next;
    logic signed [31:0] d2_reg, d2_next;
    logic signed [31:0] oi_reg, oi_next;
    logic signed [31:0] ii_reg, ii_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [MW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [31:0] drive_reg, drive_next;
    logic               valid_reg, valid_next;

    logic signed [MW-1:0] tgt_w, ang_w, rate_w;
    logic signed [32:0]   d_diff;
    logic signed [31:0]   scaled8;
    logic signed [31:0]   acc_sum;
    logic signed [31:0]   acc_cur;

    // Samples widened to Q16.16 before clamping.
    assign tgt_w  = MW'(s_target_angle) <<< SHIFT;
    assign ang_w  = MW'(s_measured_angle) <<< SHIFT;
    assign rate_w = MW'(s_measured_rate) <<< SHIFT;

    assign d_diff = 33'(err_reg) - 33'(prev_reg);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            cart_pkg::OP_MUL_OP: begin
                mul_a = MW'(err_reg);
                mul_b = BW'(cfg.outer_p_gain);
            end
            cart_pkg::OP_MUL_OI: begin
                mul_a = MW'(err_reg);
                mul_b = BW'(cfg.outer_i_gain);
            end
            cart_pkg::OP_MUL_TS: begin
                mul_a = prod_reg[MW-1:0];
                mul_b = $signed({2'b00, cfg.time_step});
            end
            cart_pkg::OP_MUL_IP: begin
                mul_a = MW'(err_reg);
                mul_b = BW'(cfg.inner_p_gain);
            end
            cart_pkg::OP_MUL_ID: begin
                mul_a = MW'(d_diff);
                mul_b = BW'(cfg.inner_d_gain);
            end
            cart_pkg::OP_MUL_II: begin
                mul_a = MW'(err_reg);
                mul_b = BW'(cfg.inner_i_gain);
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign scaled8 = cart_pkg::sat32(WW'(prod_reg >>> cart_pkg::GAIN_FRAC));
    assign acc_cur = (op == cart_pkg::OP_OI) ? oi_reg : ii_reg;
    assign acc_sum = cart_pkg::sat32(WW'(acc_cur)
                     + WW'(prod_reg >>> (cart_pkg::GAIN_FRAC + cart_pkg::DT_FRAC)));

    assign out_busy = valid_reg && !m_ready;

    always_comb begin
        err_next   = err_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        d2_next    = d2_reg;
        oi_next    = oi_reg;
        ii_next    = ii_reg;
        prev_next  = prev_reg;
        drive_next = drive_reg;
        valid_next = valid_reg && !m_ready;
        case (op)
            cart_pkg::OP_E1: begin
                err_next = cart_pkg::sat32(WW'(tgt_reg) - WW'(ang_reg));
            end
            cart_pkg::OP_P1: begin
                p1_next = scaled8;
            end
            cart_pkg::OP_OI: begin
                if (cart_pkg::integ_go(oi_reg, err_reg, cart_pkg::OUTER_LIMIT,
                                       cart_pkg::OUTER_EDGE)) begin
                    oi_next = acc_sum;
                end
            end
            cart_pkg::OP_E2: begin
                err_next = cart_pkg::sat32(WW'(p1_reg) - WW'(rate_reg));
            end
            cart_pkg::OP_P2: begin
                p2_next = scaled8;
            end
            cart_pkg::OP_D2: begin
                d2_next   = scaled8;
                prev_next = err_reg;
            end
            cart_pkg::OP_II: begin
                if (cart_pkg::integ_go(ii_reg, err_reg, cart_pkg::INNER_LIMIT,
                                       cart_pkg::INNER_EDGE)) begin
                    ii_next = acc_sum;
                end
            end
            cart_pkg::OP_DRIVE: begin
                drive_next = cart_pkg::sat32(WW'(p2_reg) + WW'(d2_reg)
                                             + WW'(ii_reg) + WW'(oi_reg));
                valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (op == cart_pkg::OP_LOAD) begin
            tgt_reg  <= cart_pkg::sat32(WW'(tgt_w));
            ang_reg  <= cart_pkg::sat32(WW'(ang_w));
            rate_reg <= cart_pkg::sat32(WW'(rate_w));
        end
        prod_reg  <= prod_next;
        err_reg   <= err_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        d2_reg    <= d2_next;
        drive_reg <= drive_next;
    end

    // Loop state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oi_reg    <= '0;
            ii_reg    <= '0;
            prev_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            oi_reg    <= oi_next;
            ii_reg    <= ii_next;
            prev_reg  <= prev_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_drive = drive_reg;

endmodule

`default_nettype wire

/* hdl/cascade_angle_rate_pid_top.sv */
// Cascaded angle/rate PID controller. Each input word carries a target angle, a measured
// angle and a measured rate as signed fixed-point samples; the block answers every word with
// exactly one drive word in signed Q16.16, clamped to the 32-bit range. The outer angle loop
// scales the angle error by its proportional gain and keeps its own integral; the inner rate
// loop runs a full PID on the difference between that proportional term and the measured
// rate, and the drive is the sum of the inner P, D and I terms plus the outer integral. Both
// integrals stop winding up at +/-270 (outer) and +/-300 (inner) unless the error pulls them
// back toward zero. Each input word is carried from acceptance into the output register by a
// sequencer that steps all products through one shared 48 x 18 multiplier. A new word is
// accepted in the cycle after a result is loaded, even while that result still waits to be
// taken, but no new word is taken while the sequencer is still working on the last one.
// Gains and the time step are set through the APB-style port and should only be
// written while no sample is being processed.
`default_nettype none

module cascade_angle_rate_pid_top #(
    parameter int SAMPLE_WIDTH  = cart_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = cart_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // APB-style configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [cart_pkg::ADDR_WIDTH-1:0]    paddr,
    input  wire logic [cart_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic      [cart_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                                    pready,

    // Sample input channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     s_target_angle,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     s_measured_angle,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     s_measured_rate,

    // Drive output channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [31:0]                      m_drive
);

    cart_pkg::cfg_t   cfg;
    cart_pkg::dp_op_t op;
    logic             out_busy;

    // Gain and time-step registers; reset to unity proportional gains and a 2.5 ms step.
    cart_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The sequencer walks one sample through the outer loop and then the inner loop,
    // issuing one datapath operation per cycle. It waits in its last step only if the
    // previous drive word has not yet been taken.
    cart_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_busy (out_busy),
        .op       (op)
    );

    // The datapath holds the sample registers, the shared multiplier with its product
    // register, the two integrals, the previous inner error and the output register.
    cart_dp #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .op               (op),
        .cfg              (cfg),
        .s_target_angle   (s_target_angle),
        .s_measured_angle (s_measured_angle),
        .s_measured_rate  (s_measured_rate),
        .out_busy         (out_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive          (m_drive)
    );

endmodule

`default_nettype wire
